// ===== hdl/sat_pkg.sv =====
package sat_pkg;

    // default encoder width
    localparam int ENCODER_BITS_DEF = 16;

    // field widths fixed by the word formats
    localparam int CFG_W      = 16;
    localparam int SLIP_W     = 16;
    localparam int ANGLE_W    = 13;
    localparam int DELTA_OUT_W = 17;
    localparam int FRAC_W     = 11;
    localparam int WHOLE_W    = 7;
    localparam int Q_SHIFT    = 10;

    // 2 pi in q10 is 201 * 32, the modulo is split along that line
    localparam int MOD_FACTOR = 201;
    localparam int LO_BITS    = 5;
    localparam logic [ANGLE_W-1:0] ANGLE_FULL = ANGLE_W'(MOD_FACTOR << LO_BITS);

    localparam int QUEUE_DEPTH = 4;

    // register reset values
    localparam logic [CFG_W-1:0] CPR_RESET  = 16'd2048;
    localparam logic [CFG_W-1:0] GAIN_RESET = 16'd3216;

    typedef enum logic [1:0] {
        REG_COUNTS_PER_REV = 2'd0,
        REG_POLE_GAIN      = 2'd1,
        REG_REVERSE        = 2'd2
    } t_reg_idx;

    typedef enum logic {
        CMD_TICK    = 1'b0,
        CMD_RESTART = 1'b1
    } t_command;

    // control part of one queued item
    typedef struct packed {
        logic                      restart;
        logic signed [WHOLE_W-1:0] whole_slip;
    } t_item_ctrl;

endpackage

// ===== hdl/sat_front.sv =====
module sat_front #(
    parameter int ENCODER_BITS = sat_pkg::ENCODER_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_accept,
    input  logic                                     i_command,
    input  logic [ENCODER_BITS-1:0]                  i_position,
    input  logic                                     i_count_down,
    input  logic signed [sat_pkg::SLIP_W-1:0]        i_slip_rate,
    input  logic [sat_pkg::CFG_W-1:0]                i_counts_per_rev,
    input  logic                                     i_reverse,
    output sat_pkg::t_item_ctrl                      o_ctrl,
    output logic signed [((ENCODER_BITS > 16) ? ENCODER_BITS : 16) + 1:0] o_delta
);

    localparam int DW = ((ENCODER_BITS > 16) ? ENCODER_BITS : 16) + 2;

    logic [ENCODER_BITS-1:0]                r_last_pos;
    logic signed [sat_pkg::FRAC_W-1:0]      r_slip_frac;
    logic [ENCODER_BITS-1:0]                n_last_pos;
    logic signed [sat_pkg::FRAC_W-1:0]      n_slip_frac;

    logic                                   is_restart;
    logic signed [DW-1:0]                   cur_x;
    logic signed [DW-1:0]                   last_x;
    logic signed [DW-1:0]                   cpr_x;
    logic signed [DW-1:0]                   delta;
    logic signed [sat_pkg::SLIP_W:0]        rate;
    logic signed [sat_pkg::SLIP_W+1:0]      acc;
    logic [sat_pkg::SLIP_W:0]               acc_mag;
    logic [sat_pkg::WHOLE_W-1:0]            whole_mag;
    logic [sat_pkg::FRAC_W-1:0]             frac_mag;
    logic signed [sat_pkg::WHOLE_W-1:0]     whole;

    assign is_restart = (i_command == sat_pkg::CMD_RESTART);

    // wrapped position change
    always_comb begin
        cur_x  = DW'(i_position);
        last_x = DW'(r_last_pos);
        cpr_x  = DW'(i_counts_per_rev);
        delta  = cur_x - last_x;
        if (!i_count_down && (cur_x < last_x)) begin
            delta = delta + cpr_x;
        end else if (i_count_down && (last_x < cur_x)) begin
            delta = delta - cpr_x;
        end
    end

    // slip carry, whole part truncated toward zero
    always_comb begin
        rate = (sat_pkg::SLIP_W + 1)'(i_slip_rate);
        if (i_reverse) begin
            rate = -rate;
        end
        acc       = (sat_pkg::SLIP_W + 2)'(r_slip_frac) + (sat_pkg::SLIP_W + 2)'(rate);
        acc_mag   = acc[sat_pkg::SLIP_W+1] ? (sat_pkg::SLIP_W + 1)'(0) - acc[sat_pkg::SLIP_W:0]
                                           : acc[sat_pkg::SLIP_W:0];
        whole_mag = acc_mag[sat_pkg::SLIP_W:sat_pkg::Q_SHIFT];
        frac_mag  = {1'b0, acc_mag[sat_pkg::Q_SHIFT-1:0]};
        if (acc[sat_pkg::SLIP_W+1]) begin
            whole       = -$signed(whole_mag);
            n_slip_frac = -$signed(frac_mag);
        end else begin
            whole       = $signed(whole_mag);
            n_slip_frac = $signed(frac_mag);
        end
    end

    always_comb begin
        n_last_pos = is_restart ? '0 : i_position;
        if (is_restart) begin
            o_ctrl.restart    = 1'b1;
            o_ctrl.whole_slip = '0;
            o_delta           = '0;
        end else begin
            o_ctrl.restart    = 1'b0;
            o_ctrl.whole_slip = whole;
            o_delta           = delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos  <= '0;
            r_slip_frac <= '0;
        end else if (i_accept) begin
            r_last_pos <= n_last_pos;
            if (!is_restart) begin
                r_slip_frac <= n_slip_frac;
            end
        end
    end

endmodule

// ===== hdl/sat_queue.sv =====
module sat_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = $clog2(sat_pkg::QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [sat_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;

    assign o_full  = (r_count == (AW + 1)'(sat_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ===== hdl/sat_back.sv =====
module sat_back #(
    parameter int ENCODER_BITS = sat_pkg::ENCODER_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_q_empty,
    output logic                                     o_q_pop,
    input  sat_pkg::t_item_ctrl                      i_ctrl,
    input  logic signed [((ENCODER_BITS > 16) ? ENCODER_BITS : 16) + 1:0] i_delta,
    input  logic [sat_pkg::CFG_W-1:0]                i_pole_gain,
    input  logic                                     i_reverse,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [sat_pkg::ANGLE_W-1:0]              o_angle,
    output logic [sat_pkg::DELTA_OUT_W-1:0]          o_delta
);

    localparam int DW   = ((ENCODER_BITS > 16) ? ENCODER_BITS : 16) + 2;
    localparam int PW   = DW + sat_pkg::CFG_W + 1;
    localparam int SH   = sat_pkg::Q_SHIFT + sat_pkg::LO_BITS;
    localparam int YW   = PW - SH;
    localparam int UW   = YW + 1;
    localparam int KSH  = UW + 8;
    localparam int MW   = KSH - 7;
    localparam int QW   = UW - 7;
    localparam int RW   = sat_pkg::ANGLE_W - sat_pkg::LO_BITS;
    localparam int WW   = sat_pkg::ANGLE_W + 2;
    // multiple of 201 that lifts any scaled value to non-negative
    localparam logic [UW-1:0] C_OFF = UW'((((64'd1 << (YW - 1)) + 64'(sat_pkg::MOD_FACTOR)
        - 64'd1) / 64'(sat_pkg::MOD_FACTOR)) * 64'(sat_pkg::MOD_FACTOR));
    // exact reciprocal of 201 for UW-bit values
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << KSH) + 64'(sat_pkg::MOD_FACTOR)
        - 64'd1) / 64'(sat_pkg::MOD_FACTOR));

    logic en;

    // stage 1: scaled position product
    logic                                r_v1;
    sat_pkg::t_item_ctrl                 r_c1;
    logic [sat_pkg::DELTA_OUT_W-1:0]     r_d1;
    logic signed [PW-1:0]                r_p1;
    logic signed [PW-1:0]                prod;
    logic signed [sat_pkg::CFG_W:0]      gain_s;

    // stage 2: lifted value and low bits
    logic                                r_v2;
    sat_pkg::t_item_ctrl                 r_c2;
    logic [sat_pkg::DELTA_OUT_W-1:0]     r_d2;
    logic [UW-1:0]                       r_u2;
    logic [sat_pkg::LO_BITS-1:0]         r_lo2;
    logic [UW-1:0]                       n_u2;

    // stage 3: quotient by 201
    logic                                r_v3;
    sat_pkg::t_item_ctrl                 r_c3;
    logic [sat_pkg::DELTA_OUT_W-1:0]     r_d3;
    logic [UW-1:0]                       r_u3;
    logic [sat_pkg::LO_BITS-1:0]         r_lo3;
    logic [QW-1:0]                       r_q3;
    logic [UW+MW-1:0]                    qm;

    // stage 4: quotient times 201
    logic                                r_v4;
    sat_pkg::t_item_ctrl                 r_c4;
    logic [sat_pkg::DELTA_OUT_W-1:0]     r_d4;
    logic [UW-1:0]                       r_u4;
    logic [sat_pkg::LO_BITS-1:0]         r_lo4;
    logic [UW-1:0]                       r_q201;

    // stage 5: angle increment in 0..6431
    logic                                r_v5;
    logic                                r_rst5;
    logic [sat_pkg::DELTA_OUT_W-1:0]     r_d5;
    logic [sat_pkg::ANGLE_W-1:0]         r_w5;
    logic [UW-1:0]                       rem_full;
    logic [sat_pkg::ANGLE_W-1:0]         rem6432;
    logic signed [WW-1:0]                w_sum;
    logic [sat_pkg::ANGLE_W-1:0]         n_w5;

    // output stage and angle state
    logic                                r_ovalid;
    logic [sat_pkg::ANGLE_W-1:0]         r_angle;
    logic [sat_pkg::ANGLE_W-1:0]         n_angle;
    logic [sat_pkg::ANGLE_W:0]           a_sum;
    logic [sat_pkg::ANGLE_W-1:0]         r_oangle;
    logic [sat_pkg::DELTA_OUT_W-1:0]     r_odelta;

    assign en      = !r_ovalid || i_ready;
    assign o_q_pop = en && !i_q_empty;

    assign gain_s = {1'b0, i_pole_gain};
    assign prod   = PW'(gain_s) * PW'(i_delta);

    // floor shift by 15 keeps the low five angle bits apart
    assign n_u2 = {r_p1[PW-1], r_p1[PW-1:SH]} + C_OFF;

    assign qm = (UW + MW)'(r_u2) * (UW + MW)'(RECIP);

    always_comb begin
        rem_full = r_u4 - r_q201;
        rem6432  = {rem_full[RW-1:0], r_lo4};
        w_sum    = $signed({2'b00, rem6432}) + WW'(r_c4.whole_slip);
        if (w_sum < 0) begin
            n_w5 = sat_pkg::ANGLE_W'(w_sum + $signed({2'b00, sat_pkg::ANGLE_FULL}));
        end else if (w_sum >= $signed({2'b00, sat_pkg::ANGLE_FULL})) begin
            n_w5 = sat_pkg::ANGLE_W'(w_sum - $signed({2'b00, sat_pkg::ANGLE_FULL}));
        end else begin
            n_w5 = sat_pkg::ANGLE_W'(w_sum);
        end
    end

    always_comb begin
        a_sum = {1'b0, r_angle} + {1'b0, r_w5};
        if (r_rst5) begin
            n_angle = '0;
        end else if (a_sum >= {1'b0, sat_pkg::ANGLE_FULL}) begin
            n_angle = sat_pkg::ANGLE_W'(a_sum - {1'b0, sat_pkg::ANGLE_FULL});
        end else begin
            n_angle = a_sum[sat_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_v5     <= 1'b0;
            r_ovalid <= 1'b0;
            r_angle  <= '0;
        end else if (en) begin
            r_v1     <= !i_q_empty;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            r_v5     <= r_v4;
            r_ovalid <= r_v5;
            if (r_v5) begin
                r_angle <= n_angle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1     <= i_ctrl;
            r_d1     <= i_delta[sat_pkg::DELTA_OUT_W-1:0];
            r_p1     <= prod;
            r_c2     <= r_c1;
            r_d2     <= r_d1;
            r_u2     <= n_u2;
            r_lo2    <= r_p1[SH-1:sat_pkg::Q_SHIFT];
            r_c3     <= r_c2;
            r_d3     <= r_d2;
            r_u3     <= r_u2;
            r_lo3    <= r_lo2;
            r_q3     <= qm[KSH +: QW];
            r_c4     <= r_c3;
            r_d4     <= r_d3;
            r_u4     <= r_u3;
            r_lo4    <= r_lo3;
            r_q201   <= UW'(r_q3) * UW'(sat_pkg::MOD_FACTOR);
            r_rst5   <= r_c4.restart;
            r_d5     <= r_d4;
            r_w5     <= n_w5;
            r_odelta <= r_d5;
            r_oangle <= i_reverse ? sat_pkg::ANGLE_FULL - n_angle : n_angle;
        end
    end

    assign o_valid = r_ovalid;
    assign o_angle = r_oangle;
    assign o_delta = r_odelta;

endmodule

// ===== hdl/slip_angle_tracker.sv =====
// throughput: one word per cycle while the output does not stall, set by the
// 6-stage multiply/modulo pipeline
// a 4-entry queue between decode and pipeline takes input while the output stalls
// reset (synchronous, active low) clears last position, angle, slip carry, queue
// and pipeline, and loads counts_per_rev 2048, pole_gain 3216, reverse 0
module slip_angle_tracker #(
    parameter int ENCODER_BITS = sat_pkg::ENCODER_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // encoder_position, count_down, slip_rate, zero fill
    input  logic [((ENCODER_BITS + 17 + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // command
    input  logic [0:0]                             i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // angle_out, position_delta, zero fill
    output logic [31:0]                            o_m_axis_tdata,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [1:0]                             i_cfg_index,
    input  logic [sat_pkg::CFG_W-1:0]              i_cfg_data
);

    localparam int DW = ((ENCODER_BITS > 16) ? ENCODER_BITS : 16) + 2;
    localparam int QW = DW + $bits(sat_pkg::t_item_ctrl);

    logic [sat_pkg::CFG_W-1:0] r_counts_per_rev;
    logic [sat_pkg::CFG_W-1:0] r_pole_gain;
    logic                      r_reverse;

    logic                                 s_accept;
    logic                                 q_full;
    logic                                 q_empty;
    logic                                 q_pop;
    sat_pkg::t_item_ctrl                  f_ctrl;
    logic signed [DW-1:0]                 f_delta;
    logic [QW-1:0]                        q_rdata;
    sat_pkg::t_item_ctrl                  b_ctrl;
    logic signed [DW-1:0]                 b_delta;
    logic [sat_pkg::ANGLE_W-1:0]          out_angle;
    logic [sat_pkg::DELTA_OUT_W-1:0]      out_delta;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !q_full;
    assign s_accept        = i_s_axis_tvalid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts_per_rev <= sat_pkg::CPR_RESET;
            r_pole_gain      <= sat_pkg::GAIN_RESET;
            r_reverse        <= 1'b0;
        end else if (i_cfg_valid) begin
            case (sat_pkg::t_reg_idx'(i_cfg_index))
                sat_pkg::REG_COUNTS_PER_REV: r_counts_per_rev <= i_cfg_data;
                sat_pkg::REG_POLE_GAIN:      r_pole_gain      <= i_cfg_data;
                sat_pkg::REG_REVERSE:        r_reverse        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    sat_front #(
        .ENCODER_BITS(ENCODER_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (s_accept),
        .i_command       (i_s_axis_tuser[0]),
        .i_position      (i_s_axis_tdata[ENCODER_BITS-1:0]),
        .i_count_down    (i_s_axis_tdata[ENCODER_BITS]),
        .i_slip_rate     ($signed(i_s_axis_tdata[ENCODER_BITS+sat_pkg::SLIP_W:ENCODER_BITS+1])),
        .i_counts_per_rev(r_counts_per_rev),
        .i_reverse       (r_reverse),
        .o_ctrl          (f_ctrl),
        .o_delta         (f_delta)
    );

    sat_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (s_accept),
        .i_wdata({f_ctrl, f_delta}),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_rdata(q_rdata),
        .o_empty(q_empty)
    );

    assign b_ctrl  = q_rdata[QW-1:DW];
    assign b_delta = $signed(q_rdata[DW-1:0]);

    sat_back #(
        .ENCODER_BITS(ENCODER_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_ctrl     (b_ctrl),
        .i_delta    (b_delta),
        .i_pole_gain(r_pole_gain),
        .i_reverse  (r_reverse),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_angle    (out_angle),
        .o_delta    (out_delta)
    );

    assign o_m_axis_tdata = {2'b00, out_delta, out_angle};

    // forward angle stays below a full turn
    a_fwd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !r_reverse) |-> (out_angle < sat_pkg::ANGLE_FULL))
        else $error("forward angle out of range");

    // mirrored angle lies in 1..6432
    a_rev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_reverse) |->
        ((out_angle != '0) && (out_angle <= sat_pkg::ANGLE_FULL)))
        else $error("mirrored angle out of range");

    // reset empties the output and the queue
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("output valid or queue busy after reset");

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sat_pkg::*;

    localparam int ENC_W = ENCODER_BITS_DEF;
    localparam int TDATA_W = ((ENC_W + 17 + 7) / 8) * 8;
    localparam int Q_ONE = 1 << Q_SHIFT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SINK_HOLD_CYCLES = 200;

    typedef struct {
        logic [ANGLE_W-1:0]            angle;
        logic signed [DELTA_OUT_W-1:0] delta;
    } t_angle_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [TDATA_W-1:0]   i_s_axis_tdata;
    logic [0:0]           i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [31:0]          o_m_axis_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [1:0]           i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    slip_angle_tracker #(.ENCODER_BITS(ENC_W)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // shadow registers and tracker state
    int unsigned      cfg_cpr = CPR_RESET;
    int unsigned      cfg_gain = GAIN_RESET;
    logic             cfg_rev = 1'b0;
    logic [ENC_W-1:0] trk_last_pos = '0;
    longint           trk_angle = 0;
    longint           trk_slip_frac = 0;

    t_angle_word pending_words[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          gaps_on = 1'b0;
    bit          sink_hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_angle_word advance_angle(t_command cmd, logic [ENC_W-1:0] pos,
                                                  logic down, logic signed [SLIP_W-1:0] rate);
        t_angle_word w;
        longint cur, prev, cpr, dlt, rt, acc, whl, sum;
        if (cmd == CMD_RESTART) begin
            trk_last_pos = '0;
            trk_angle = 0;
            dlt = 0;
        end else begin
            cur = pos;
            prev = trk_last_pos;
            cpr = cfg_cpr;
            if (!down) begin
                dlt = (cur < prev) ? cur + cpr - prev : cur - prev;
            end else begin
                dlt = (prev < cur) ? -(prev + cpr - cur) : -(prev - cur);
            end
            trk_last_pos = pos;
            rt = rate;
            if (cfg_rev) begin
                rt = -rt;
            end
            // whole part truncates toward zero, the rest carries over
            acc = trk_slip_frac + rt;
            whl = acc / Q_ONE;
            trk_slip_frac = acc - whl * Q_ONE;
            sum = trk_angle + ((longint'(cfg_gain) * dlt) >>> Q_SHIFT) + whl;
            sum = sum % longint'(ANGLE_FULL);
            if (sum < 0) begin
                sum += longint'(ANGLE_FULL);
            end
            trk_angle = sum;
        end
        w.angle = ANGLE_W'(cfg_rev ? longint'(ANGLE_FULL) - trk_angle : trk_angle);
        w.delta = DELTA_OUT_W'(dlt);
        return w;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_angle_word want;
        logic [ANGLE_W-1:0] got_angle;
        logic signed [DELTA_OUT_W-1:0] got_delta;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_angle = o_m_axis_tdata[ANGLE_W-1:0];
            got_delta = o_m_axis_tdata[ANGLE_W +: DELTA_OUT_W];
            if (pending_words.size() == 0) begin
                flag_mismatch("unexpected word, angle", got_angle, -1);
            end else begin
                want = pending_words.pop_front();
                if (got_angle !== want.angle) begin
                    flag_mismatch("angle_out", got_angle, want.angle);
                end
                if (got_delta !== want.delta) begin
                    flag_mismatch("position_delta", got_delta, want.delta);
                end
            end
        end
    end

    // receiver side: random stall bursts, or one long hold on request
    initial begin
        int n;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                i_m_axis_tready = 1'b0;
                for (n = 0; n < SINK_HOLD_CYCLES; n++) begin
                    @(negedge i_clk);
                end
                i_m_axis_tready = 1'b1;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 19);
                i_m_axis_tready = 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready = i_rst_n;
            end
        end
    end

    task automatic send_word(input t_command cmd, input logic [ENC_W-1:0] pos,
                             input logic down, input logic signed [SLIP_W-1:0] rate);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser = cmd;
        i_s_axis_tdata = '0;
        i_s_axis_tdata[ENC_W-1:0] = pos;
        i_s_axis_tdata[ENC_W] = down;
        i_s_axis_tdata[ENC_W+1 +: SLIP_W] = rate;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_words.push_back(advance_angle(cmd, pos, down, rate));
    endtask

    // drops valid and waits for every outstanding word
    task automatic wait_results_done();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        wait_results_done();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_COUNTS_PER_REV: cfg_cpr = value;
            REG_POLE_GAIN:      cfg_gain = value;
            REG_REVERSE:        cfg_rev = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(input int unsigned cpr, input int unsigned gain, input bit rev);
        write_reg(REG_COUNTS_PER_REV, CFG_W'(cpr));
        write_reg(REG_POLE_GAIN, CFG_W'(gain));
        // upper data bits are don't care for the direction flag
        write_reg(REG_REVERSE, {(CFG_W - 1)'($urandom), rev});
    endtask

    // mostly plausible encoder motion, some restarts and some arbitrary positions
    task automatic send_random_tick();
        int sel;
        longint span, step, stepmax, p;
        logic down;
        logic signed [SLIP_W-1:0] rate;
        sel = $urandom_range(0, 99);
        down = 1'($urandom_range(0, 1));
        rate = ($urandom_range(0, 1) == 0) ? SLIP_W'($urandom)
                                           : SLIP_W'($urandom_range(0, 4096) - 2048);
        if (sel < 5) begin
            send_word(CMD_RESTART, ENC_W'($urandom), down, rate);
        end else if (sel < 15 || cfg_cpr == 0) begin
            send_word(CMD_TICK, ENC_W'($urandom), down, rate);
        end else begin
            span = cfg_cpr;
            stepmax = ($urandom_range(0, 9) == 0 || span <= 200) ? span - 1 : 200;
            step = $urandom_range(0, int'(stepmax));
            p = longint'(trk_last_pos) % span;
            p = down ? p - step : p + step;
            if (p < 0) begin
                p += span;
            end
            if (p >= span) begin
                p -= span;
            end
            send_word(CMD_TICK, ENC_W'(p), down, rate);
        end
    endtask

    task automatic test_directed();
        // reset settings: wrap in both directions, slip extremes, out of range position
        send_word(CMD_TICK, 16'd0, 1'b0, 16'sd0);
        send_word(CMD_TICK, 16'd2047, 1'b0, 16'sd32767);
        send_word(CMD_TICK, 16'd5, 1'b0, -16'sd32768);
        send_word(CMD_TICK, 16'd2040, 1'b1, -16'sd1);
        send_word(CMD_TICK, 16'd0, 1'b1, 16'sd1023);
        send_word(CMD_TICK, 16'hFFFF, 1'b0, 16'sd1024);
        send_word(CMD_TICK, 16'd100, 1'b0, -16'sd1024);
        send_word(CMD_RESTART, 16'hFFFF, 1'b1, 16'sh5A5A);
        send_word(CMD_TICK, 16'd3000, 1'b1, 16'sd1);
        // zero counts per rev, largest gain, mirrored angle
        set_config(0, 65535, 1'b1);
        send_word(CMD_TICK, 16'hFFFF, 1'b0, 16'sd700);
        send_word(CMD_TICK, 16'd0, 1'b0, 16'sd32767);
        send_word(CMD_TICK, 16'hFFFF, 1'b1, -16'sd32768);
        send_word(CMD_RESTART, 16'd0, 1'b0, 16'sd0);
        send_word(CMD_TICK, 16'd1, 1'b1, 16'sd32767);
        send_word(CMD_TICK, 16'd1, 1'b1, -16'sd32768);
        // largest counts per rev, zero gain
        set_config(65535, 0, 1'b0);
        send_word(CMD_TICK, 16'd65534, 1'b0, -16'sd5);
        send_word(CMD_TICK, 16'd0, 1'b1, 16'sd2047);
        send_word(CMD_RESTART, 16'h8000, 1'b0, -16'sd2047);
        wait_results_done();
    endtask

    task automatic test_random_settings();
        int unsigned cprs[8] = '{1, 65535, 2048, 0, 3, 65535, 0, 0};
        int unsigned gains[8] = '{0, 65535, 3216, 0, 65535, 1, 0, 0};
        bit revs[8] = '{0, 1, 0, 1, 0, 0, 0, 1};
        int ph, k;
        for (ph = 0; ph < 8; ph++) begin
            if (ph >= 6) begin
                set_config($urandom_range(1, 65535), $urandom_range(0, 65535),
                           1'($urandom_range(0, 1)));
            end else begin
                set_config(cprs[ph], gains[ph], revs[ph]);
            end
            // alternate stretches with and without idling
            gaps_on = (ph % 3) != 2;
            for (k = 0; k < 50; k++) begin
                send_random_tick();
            end
        end
        wait_results_done();
    endtask

    task automatic test_backpressure();
        int k;
        set_config(4096, 5000, 1'b1);
        gaps_on = 1'b0;
        sink_hold_req = 1'b1;
        for (k = 0; k < 40; k++) begin
            send_random_tick();
        end
        // sender pauses until the block has emptied
        wait_results_done();
        gaps_on = 1'b1;
        for (k = 0; k < 20; k++) begin
            send_random_tick();
        end
        wait_results_done();
    endtask

    task automatic test_steady_stream();
        int k;
        set_config($urandom_range(1, 65535), $urandom_range(0, 65535), 1'b0);
        gaps_on = 1'b0;
        for (k = 0; k < 40; k++) begin
            send_random_tick();
        end
        wait_results_done();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = CMD_TICK;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_COUNTS_PER_REV;
        i_cfg_data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        gaps_on = 1'b1;
        test_random_settings();
        test_backpressure();
        test_steady_stream();

        wait_results_done();
        repeat (12) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sat_pkg.sv
hdl/sat_front.sv
hdl/sat_queue.sv
hdl/sat_back.sv
hdl/slip_angle_tracker.sv
sim/testbench.sv
